>>> src/spq_pkg.sv
// Package for the sorted-list priority queue.
// Holds the entry and command types and the op and status codes; no dependencies.
package spq_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        prio;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t item;
  } cell_cmd_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it with its neighbors.
// Depends on spq_pkg for entry_t and cell_cmd_t.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occ,        // slot holds a live entry
  input  entry_t    left_entry,
  input  logic      left_move,  // left neighbor is pushed right on this insert
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      move
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Sorted order makes move monotone along the chain: first set cell takes the item.
  assign move = !occ || (entry_r.prio > cmd.item.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && move) begin
      entry_nxt = left_move ? left_entry : cmd.item;
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> src/stable_priority_queue_top.sv
// Sorted-list priority queue: one insert or pop item per clock cycle while in_stall is
// low. Entries sit in a chain of DEPTH cells in service order; an insert compares its
// priority in every cell at once and the cells behind the insertion point shift one place,
// a pop shifts the whole chain toward the head. Equal priorities leave in arrival order.
// Each item gives one result in the cycle after acceptance, held in an output register;
// in_stall rises only while that register is full and stalled. Inserts into a full queue
// are dropped (status 1), pops of an empty queue return status 2. Slot contents need no
// clearing after reset. Depends on spq_pkg and spq_cell.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [31:0] in_item_value,
  input  logic [15:0]        in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_popped_value,
  output logic [15:0]        out_popped_priority,
  output logic [4:0]         out_fill_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [15:0]        prio_r, prio_nxt;
  logic [CW+4:0]      count_ext;

  logic      accept;
  logic      is_full, is_empty;
  cell_cmd_t cmd;
  entry_t    entries [DEPTH];
  logic      moves   [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.item.value = in_item_value;
    cmd.item.prio  = in_item_priority;
    cmd.ins        = accept && (op_t'(in_op) == OP_INSERT) && !is_full;
    cmd.pop        = accept && (op_t'(in_op) == OP_POP) && !is_empty;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CW-1:0] KI = CW'(k);
    entry_t left_e, right_e;
    logic   left_m;

    if (k == 0) begin : g_head
      assign left_e = '0;
      assign left_m = 1'b0;
    end else begin : g_body
      assign left_e = entries[k-1];
      assign left_m = moves[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (KI < count_r),
      .left_entry  (left_e),
      .left_move   (left_m),
      .right_entry (right_e),
      .entry       (entries[k]),
      .move        (moves[k])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    value_nxt     = value_r;
    prio_nxt      = prio_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      value_nxt     = '0;
      prio_nxt      = '0;
      case (op_t'(in_op))
        OP_INSERT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_DONE;
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_DONE;
            value_nxt  = entries[0].value;
            prio_nxt   = entries[0].prio;
            count_nxt  = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    prio_r   <= prio_nxt;
  end

  assign count_ext           = {5'd0, count_r};
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_value    = value_r;
  assign out_popped_priority = prio_r;
  assign out_fill_count      = count_ext[4:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("occupancy above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not drop occupancy by one");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op_t'(in_op) == OP_INSERT) && is_full |=> $stable(count_r) && status_r == ST_FULL)
    else $error("insert into full queue changed occupancy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_DONE |-> value_r == '0 && prio_r == '0)
    else $error("failed item carries nonzero popped data");

endmodule
